// File: sv/ifrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_pkg
// Shared types, constants and decode helpers for the IMU frame receiver.
// ----------------------------------------------------------------------------
package ifrd_pkg;

  // Frame layout
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam int unsigned FRAME_LEN  = 11;
  localparam int unsigned POS_W      = 4;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  // Field widths
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned AXIS_W = 28;
  localparam int unsigned TEMP_W = 15;

  // Axis scale factors (units of 2^-16 per raw LSB)
  localparam int unsigned SCALE_W = 13;
  localparam logic [SCALE_W-1:0] SCALE_ACCEL = 13'd32;
  localparam logic [SCALE_W-1:0] SCALE_GYRO  = 13'd4000;
  localparam logic [SCALE_W-1:0] SCALE_ANGLE = 13'd360;

  // Temperature: raw*100/340 == raw*5/17, division by reciprocal multiply
  localparam int unsigned TMAG_W     = 18;
  localparam int unsigned RECIP_W    = 22;
  localparam int unsigned RECIP_SH   = 26;
  localparam logic [RECIP_W-1:0] TEMP_RECIP = 22'd3947581;  // ceil(2^26/17)
  localparam int unsigned TQ_W       = 14;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 15'sd3625;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } ifrd_kind_e;

  // Raw frame contents handed from the collector to the scaler
  typedef struct packed {
    ifrd_kind_e              kind;
    logic signed [RAW_W-1:0] x;
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] z;
    logic signed [RAW_W-1:0] t;
  } ifrd_raw_t;

  // Type byte decode: bit 2 marks a known type, low bits give the kind
  function automatic logic [2:0] type_decode(input logic [7:0] type_byte);
    logic [2:0] res;
    case (type_byte)
      TYPE_ACCEL: res = {1'b1, KIND_ACCEL};
      TYPE_GYRO:  res = {1'b1, KIND_GYRO};
      TYPE_ANGLE: res = {1'b1, KIND_ANGLE};
      default:    res = 3'b000;
    endcase
    return res;
  endfunction

  function automatic logic [SCALE_W-1:0] kind_scale(input ifrd_kind_e kind);
    logic [SCALE_W-1:0] res;
    case (kind)
      KIND_ACCEL: res = SCALE_ACCEL;
      KIND_GYRO:  res = SCALE_GYRO;
      KIND_ANGLE: res = SCALE_ANGLE;
      default:    res = '0;
    endcase
    return res;
  endfunction

endpackage

// File: sv/ifrd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_byte_if
// Valid/ready channel carrying one received serial byte per request.
// ----------------------------------------------------------------------------
interface ifrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/ifrd_meas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_meas_if
// Valid/ready channel carrying one decoded measurement per request.
// ----------------------------------------------------------------------------
interface ifrd_meas_if import ifrd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               packet_kind;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;
  logic signed [TEMP_W-1:0] temp_centi;

  modport source (output valid, output packet_kind, output axis_x, output axis_y,
                  output axis_z, output temp_centi, input ready);
  modport sink   (input valid, input packet_kind, input axis_x, input axis_y,
                  input axis_z, input temp_centi, output ready);
endinterface

// File: sv/imu_frame_receiver_decoder_unit.sv
`timescale 1ns / 1ps
// A measurement passes through the holding register, product register and result
//   register after its checksum byte is accepted.
// Throughput: one byte per cycle; ready drops only when all three registers
//   hold requests that the sink has not taken.
// Reset: rst_ni clears the frame position and all valid flags; the frame store
//   is not cleared.
// ----------------------------------------------------------------------------
// imu_frame_receiver_decoder_unit
// Receives 11-byte IMU frames and outputs scaled acceleration, rate or angle.
// ----------------------------------------------------------------------------
module imu_frame_receiver_decoder_unit import ifrd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ifrd_byte_if.sink    rx_i,
  ifrd_meas_if.source  meas_o
);

  logic       raw_valid;
  logic       raw_ready;
  ifrd_raw_t  raw;
  ifrd_kind_e res_kind;

  // Frame collection
  ifrd_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (rx_i.valid),
    .byte_i       (rx_i.rx_byte),
    .byte_ready_o (rx_i.ready),
    .raw_valid_o  (raw_valid),
    .raw_ready_i  (raw_ready),
    .raw_o        (raw)
  );

  // Scaling pipeline
  ifrd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .raw_valid_i (raw_valid),
    .raw_ready_o (raw_ready),
    .raw_i       (raw),
    .res_valid_o (meas_o.valid),
    .res_ready_i (meas_o.ready),
    .res_kind_o  (res_kind),
    .res_x_o     (meas_o.axis_x),
    .res_y_o     (meas_o.axis_y),
    .res_z_o     (meas_o.axis_z),
    .res_temp_o  (meas_o.temp_centi)
  );

  assign meas_o.packet_kind = res_kind;

endmodule

// File: sv/ifrd_collect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_collect
// Header hunt, byte position counter and frame store; emits the raw fields
// of each complete frame with a known type into a holding register.
// ----------------------------------------------------------------------------
module ifrd_collect import ifrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_valid_i,
  input  logic [7:0] byte_i,
  output logic      byte_ready_o,
  output logic      raw_valid_o,
  input  logic      raw_ready_i,
  output ifrd_raw_t raw_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       frame_q [1:POS_LAST-1];
  logic             raw_valid_q, raw_valid_d;
  ifrd_raw_t        raw_q, raw_d;
  logic             byte_acc;
  logic [2:0]       type_dec;

  assign byte_ready_o = !raw_valid_q || raw_ready_i;
  assign byte_acc     = byte_valid_i && byte_ready_o;
  assign type_dec     = type_decode(frame_q[1]);

  // Position and frame-complete handling
  always_comb begin
    pos_d       = pos_q;
    raw_valid_d = raw_valid_q && !raw_ready_i;
    raw_d       = raw_q;
    if (byte_acc) begin
      if (pos_q == '0) begin
        if (byte_i == HEADER_BYTE) begin
          pos_d = POS_W'(1);
        end
      end else if (pos_q < POS_LAST) begin
        pos_d = pos_q + POS_W'(1);
      end else begin
        // checksum byte closes the frame
        pos_d = '0;
        if (type_dec[2]) begin
          raw_valid_d = 1'b1;
          raw_d.kind  = ifrd_kind_e'(type_dec[1:0]);
          raw_d.x     = {frame_q[3], frame_q[2]};
          raw_d.y     = {frame_q[5], frame_q[4]};
          raw_d.z     = {frame_q[7], frame_q[6]};
          raw_d.t     = {frame_q[9], frame_q[8]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      raw_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      raw_valid_q <= raw_valid_d;
    end
  end

  // Frame store and raw holding register (no reset needed)
  always_ff @(posedge clk_i) begin
    if (byte_acc && pos_q != '0 && pos_q < POS_LAST) begin
      frame_q[pos_q] <= byte_i;
    end
    raw_q <= raw_d;
  end

  assign raw_valid_o = raw_valid_q;
  assign raw_o       = raw_q;

endmodule

// File: sv/ifrd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_scale
// Two-stage fixed-point scaling: product register, then the result register
// with the temperature reciprocal shift, sign and offset.
// ----------------------------------------------------------------------------
module ifrd_scale import ifrd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     raw_valid_i,
  output logic                     raw_ready_o,
  input  ifrd_raw_t                raw_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output ifrd_kind_e               res_kind_o,
  output logic signed [AXIS_W-1:0] res_x_o,
  output logic signed [AXIS_W-1:0] res_y_o,
  output logic signed [AXIS_W-1:0] res_z_o,
  output logic signed [TEMP_W-1:0] res_temp_o
);

  localparam int unsigned PROD_W  = RAW_W + SCALE_W + 1;
  localparam int unsigned TN_W    = TMAG_W + 1;
  localparam int unsigned TPROD_W = TMAG_W + RECIP_W;

  // Stage enables: a stage moves when its successor is empty or moving
  logic prod_valid_q, res_valid_q;
  logic en_prod, en_res;

  assign en_res      = !res_valid_q || res_ready_i;
  assign en_prod     = !prod_valid_q || en_res;
  assign raw_ready_o = en_prod;

  // Product stage
  logic signed [PROD_W-1:0] scale_s;
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [TN_W-1:0]   t5;
  logic [TMAG_W-1:0]        tmag;
  logic [TPROD_W-1:0]       tprod;

  ifrd_kind_e               kind_q;
  logic signed [AXIS_W-1:0] px_q, py_q, pz_q;
  logic [TPROD_W-1:0]       tprod_q;
  logic                     tneg_q;

  always_comb begin
    scale_s = $signed({{(PROD_W-SCALE_W){1'b0}}, kind_scale(raw_i.kind)});
    px      = PROD_W'(raw_i.x) * scale_s;
    py      = PROD_W'(raw_i.y) * scale_s;
    pz      = PROD_W'(raw_i.z) * scale_s;
    t5      = TN_W'(raw_i.t) * TN_W'(5);
    tmag    = t5[TN_W-1] ? TMAG_W'(-t5) : TMAG_W'(t5);
    tprod   = TPROD_W'(tmag) * TPROD_W'(TEMP_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_prod) begin
      kind_q  <= raw_i.kind;
      px_q    <= px[AXIS_W-1:0];
      py_q    <= py[AXIS_W-1:0];
      pz_q    <= pz[AXIS_W-1:0];
      tprod_q <= tprod;
      tneg_q  <= t5[TN_W-1];
    end
  end

  // Result stage: quotient by 17, restore sign, add offset
  logic [TQ_W-1:0]          tq;
  logic signed [TEMP_W-1:0] tsigned;

  ifrd_kind_e               res_kind_q;
  logic signed [AXIS_W-1:0] res_x_q, res_y_q, res_z_q;
  logic signed [TEMP_W-1:0] res_temp_q;

  always_comb begin
    tq      = tprod_q[RECIP_SH +: TQ_W];
    tsigned = tneg_q ? -$signed(TEMP_W'(tq)) : $signed(TEMP_W'(tq));
  end

  always_ff @(posedge clk_i) begin
    if (en_res) begin
      res_kind_q <= kind_q;
      res_x_q    <= px_q;
      res_y_q    <= py_q;
      res_z_q    <= pz_q;
      res_temp_q <= tsigned + TEMP_OFFSET;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (en_prod) begin
        prod_valid_q <= raw_valid_i;
      end
      if (en_res) begin
        res_valid_q <= prod_valid_q;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_kind_o  = res_kind_q;
  assign res_x_o     = res_x_q;
  assign res_y_o     = res_y_q;
  assign res_z_o     = res_z_q;
  assign res_temp_o  = res_temp_q;

endmodule

// File: sv/ifrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_checker
// Port-level checks on the measurement output of the frame receiver.
// ----------------------------------------------------------------------------
module ifrd_checker import ifrd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               packet_kind_i,
  input  logic signed [AXIS_W-1:0] axis_x_i,
  input  logic signed [TEMP_W-1:0] temp_centi_i
);

  // A stalled request holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(packet_kind_i) &&
      $stable(axis_x_i) && $stable(temp_centi_i))
    else $error("stalled measurement changed");

  // Only the three known kinds are produced
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> packet_kind_i == KIND_ACCEL || packet_kind_i == KIND_GYRO ||
      packet_kind_i == KIND_ANGLE)
    else $error("unknown packet kind");

  // Temperature stays within what a 16-bit raw value can give
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> temp_centi_i >= -15'sd6012 && temp_centi_i <= 15'sd13262)
    else $error("temperature out of range");

  // Acceleration and rate scales are multiples of 32, angle of 8
  a_axis_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> axis_x_i[2:0] == 3'b000 &&
      (packet_kind_i == KIND_ANGLE || axis_x_i[4:0] == 5'b00000))
    else $error("axis value not a multiple of its scale");

endmodule

bind imu_frame_receiver_decoder_unit ifrd_checker u_ifrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (meas_o.valid),
  .out_ready_i   (meas_o.ready),
  .packet_kind_i (meas_o.packet_kind),
  .axis_x_i      (meas_o.axis_x),
  .temp_centi_i  (meas_o.temp_centi)
);

// File: verif/ifrd_meas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrd_meas_checker
// Watches the byte and measurement channels of the IMU frame receiver. Every
// accepted byte is run through a frame decoder of its own. Each decoded
// measurement is queued, and every measurement the block hands out is
// compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module ifrd_meas_checker import ifrd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ifrd_byte_if rx_i,
  ifrd_meas_if meas_i,
  output int   fail_count_o,
  output int   pending_count_o
);

  typedef struct {
    ifrd_kind_e               kind;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic signed [TEMP_W-1:0] t;
  } meas_rec_t;

  // Decoder state: next frame slot and the bytes collected so far
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_bytes [10];
  meas_rec_t        pending_meas_q [$];

  // Signed little-endian word starting at frame byte lo
  function automatic logic signed [RAW_W-1:0] frame_word(input int lo);
    return {frame_bytes[lo+1], frame_bytes[lo]};
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    meas_rec_t next_meas;
    meas_rec_t got_meas;
    int        scale;
    int        temp_val;
    logic      known;
    if (!rst_ni) begin
      frame_pos = '0;
      pending_meas_q.delete();
      fail_count_o = 0;
    end else begin
      // Byte request: advance the frame decoder
      if (rx_i.valid && rx_i.ready) begin
        if (frame_pos == '0 && rx_i.rx_byte != HEADER_BYTE) begin
          // hunting for a header: anything else is dropped
        end else if (frame_pos < POS_LAST) begin
          frame_bytes[frame_pos] = rx_i.rx_byte;
          frame_pos = frame_pos + 1'b1;
        end else begin
          // checksum byte closes the frame, never checked
          frame_pos = '0;
          known = 1'b1;
          scale = 0;
          next_meas.kind = KIND_ACCEL;
          case (frame_bytes[1])
            TYPE_ACCEL: begin
              next_meas.kind = KIND_ACCEL;
              scale = int'(SCALE_ACCEL);
            end
            TYPE_GYRO: begin
              next_meas.kind = KIND_GYRO;
              scale = int'(SCALE_GYRO);
            end
            TYPE_ANGLE: begin
              next_meas.kind = KIND_ANGLE;
              scale = int'(SCALE_ANGLE);
            end
            default: known = 1'b0;
          endcase
          if (known) begin
            next_meas.x = AXIS_W'(int'(frame_word(2)) * scale);
            next_meas.y = AXIS_W'(int'(frame_word(4)) * scale);
            next_meas.z = AXIS_W'(int'(frame_word(6)) * scale);
            // signed division truncates toward zero
            temp_val = (int'(frame_word(8)) * 100) / 340 + int'(TEMP_OFFSET);
            next_meas.t = TEMP_W'(temp_val);
            pending_meas_q.push_back(next_meas);
          end
        end
      end

      // Measurement request: compare against the oldest decoded frame
      if (meas_i.valid && meas_i.ready) begin
        if (pending_meas_q.size() == 0) begin
          $display("%0t ns: unexpected measurement: expected none, actual kind %0d x %0d",
                   $time, meas_i.packet_kind, int'(meas_i.axis_x));
          fail_count_o++;
        end else begin
          got_meas = pending_meas_q.pop_front();
          compare_field("packet_kind", int'(got_meas.kind), int'(meas_i.packet_kind));
          compare_field("axis_x", int'(got_meas.x), int'(meas_i.axis_x));
          compare_field("axis_y", int'(got_meas.y), int'(meas_i.axis_y));
          compare_field("axis_z", int'(got_meas.z), int'(meas_i.axis_z));
          compare_field("temp_centi", int'(got_meas.t), int'(meas_i.temp_centi));
        end
      end
    end
    pending_count_o = pending_meas_q.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte stimulus for the IMU frame receiver: a few directed frames, then
// mostly well-formed random frames mixed with stray bytes and unknown types.
// Both channels idle at random; the sink holds off once long enough to stall
// the input, and the source once drains everything before going on.
// ----------------------------------------------------------------------------
module tb;
  import ifrd_pkg::*;

  localparam int unsigned ITEM_TARGET     = 1450;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES    = 10;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  int   items;
  bit   no_idle;
  bit   burst;
  bit   hold_req;
  bit   hold_done;
  bit   pause_done;

  ifrd_byte_if rx_if ();
  ifrd_meas_if meas_if ();

  imu_frame_receiver_decoder_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .meas_o (meas_if)
  );

  ifrd_meas_checker u_meas_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_i            (rx_if),
    .meas_i          (meas_if),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: too long without any request on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (meas_if.valid && meas_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Sink side: random stalls, one long hold-off on request
  initial begin
    meas_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        meas_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        meas_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        meas_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // One byte request, then maybe a short gap
  task automatic push_byte(input logic [7:0] b);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    if (!no_idle && !burst && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic quiet_sender();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] type_b, input logic [15:0] wx,
                            input logic [15:0] wy, input logic [15:0] wz,
                            input logic [15:0] wt, input logic [7:0] chk);
    push_byte(HEADER_BYTE);
    push_byte(type_b);
    push_byte(wx[7:0]);
    push_byte(wx[15:8]);
    push_byte(wy[7:0]);
    push_byte(wy[15:8]);
    push_byte(wz[7:0]);
    push_byte(wz[15:8]);
    push_byte(wt[7:0]);
    push_byte(wt[15:8]);
    push_byte(chk);
  endtask

  // Raw word, biased toward the extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] known_type();
    case ($urandom_range(0, 2))
      0:       return TYPE_ACCEL;
      1:       return TYPE_GYRO;
      default: return TYPE_ANGLE;
    endcase
  endfunction

  task automatic random_frame(input logic [7:0] type_b);
    send_frame(type_b, pick_word(), pick_word(), pick_word(), pick_word(),
               8'($urandom));
    items += FRAME_LEN;
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [7:0] stray;
    logic [7:0] odd_type;
    rst_ni = 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    no_idle    = 1'b0;
    burst      = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    items      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray bytes before a header, full-scale frames, header as checksum
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(TYPE_GYRO, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00);
    send_frame(TYPE_ANGLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, HEADER_BYTE);
    items = 24;

    while (items < ITEM_TARGET) begin
      if (!hold_done && items >= 400) begin
        // Long sink hold-off with a gapless source: fills the block
        burst    = 1'b1;
        hold_req = 1'b1;
        repeat (8) random_frame(known_type());
        burst     = 1'b0;
        hold_done = 1'b1;
      end else if (!pause_done && items >= 800) begin
        // Source waits until every measurement has drained
        quiet_sender();
        while (pending_count != 0) @(posedge clk_i);
        pause_done = 1'b1;
      end else begin
        if (items >= 1250) no_idle = 1'b1;
        case ($urandom_range(0, 19))
          0, 1: begin
            // stray bytes while aligned: never a header, so dropped
            repeat ($urandom_range(1, 3)) begin
              stray = 8'($urandom);
              if (stray == HEADER_BYTE) stray = stray ^ 8'h01;
              push_byte(stray);
              items++;
            end
          end
          2, 3: begin
            // any type byte, the header value among them
            odd_type = ($urandom_range(0, 3) == 0) ? HEADER_BYTE : 8'($urandom);
            random_frame(odd_type);
          end
          default: random_frame(known_type());
        endcase
      end
    end

    quiet_sender();
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ifrd_pkg.sv
sv/ifrd_byte_if.sv
sv/ifrd_meas_if.sv
sv/ifrd_collect.sv
sv/ifrd_scale.sv
sv/imu_frame_receiver_decoder_unit.sv
sv/ifrd_checker.sv
verif/ifrd_meas_checker.sv
verif/tb.sv
